FILE: rtl/bounded_linked_list_engine_top_defines.svh
// Assertion macros shared by the linked list engine RTL.
`ifndef BOUNDED_LINKED_LIST_ENGINE_TOP_DEFINES_SVH
`define BOUNDED_LINKED_LIST_ENGINE_TOP_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define BLL_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define BLL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bll_pkg.sv
// Shared constants and codes for the bounded linked list engine.
package bll_pkg;

	// Default storage configuration.
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Field widths of the stream transactions.
	localparam int OP_W        = 3;
	localparam int VALUE_W     = 32;
	localparam int POS_W       = 4;
	localparam int STATUS_W    = 2;
	localparam int ELEM_W      = 32;
	localparam int LEN_W       = 5;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	// Operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_PUSH    = 3'd0,
		OP_APPEND  = 3'd1,
		OP_INSERT  = 3'd2,
		OP_DEL_KEY = 3'd3,
		OP_DEL_AT  = 3'd4,
		OP_CLEAR   = 3'd5,
		OP_LIST    = 3'd6
	} op_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2
	} status_t;

endpackage

FILE: rtl/bll_node_ram.sv
// Node store memory with one write port and one registered read port.
module bll_node_ram #(
	parameter int WIDTH = bll_pkg::DATA_WIDTH_DEF,
	parameter int DEPTH = bll_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data registered and held while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/bounded_linked_list_engine_top.sv
// Bounded singly linked list engine: top level with the list sequencer.
//
// Usage: one input transaction on s_axis carries an operation, a value and a
// position; the engine answers on m_axis. Every operation but list gives one
// result with tlast high; list gives one result per element (tuser high) in
// list order, tlast on the final one, or one plain result for an empty list.
// Nodes live in two single-port-read memories (values and next links); a
// sequencer walks the links one node per cycle through the shared read port.
// Steps from acceptance to the result entering the output register, K being the
// link steps walked: push writes the node after dispatch; append and insert walk
// K links, then write the new node and two links; each of these allocates first
// when a freed slot is reused; delete at a position walks K links and delete by
// key up to the length, then frees the node found; clear, an empty list and every
// rejected operation answer straight after dispatch. The block takes one item at
// a time and is not ready until its last result is in the output register.
// Reset empties the list at once; slots are handed out from a free list and a
// high-water mark, so no clearing pass runs after reset or clear.
// A stalled receiver holds the output register and the list burst pauses
// in place; nothing is dropped.
`include "bounded_linked_list_engine_top_defines.svh"

module bounded_linked_list_engine_top #(
	parameter int DEPTH      = bll_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = bll_pkg::DATA_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// operation [2:0], value [34:3], position [38:35], zero [39]
	input  logic [bll_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// status [1:0], element [33:2], length [38:34], zero [39]
	output logic [bll_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// has_element [0]
	output logic                             m_axis_tuser,
	output logic                             m_axis_tlast
);

	localparam int IW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int SW   = (DATA_WIDTH < bll_pkg::VALUE_W) ? DATA_WIDTH : bll_pkg::VALUE_W;
	localparam int CMPW = (CW > bll_pkg::POS_W) ? CW : bll_pkg::POS_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_ALLOC,
		S_PUSH,
		S_WALK,
		S_INS_W2,
		S_FREE,
		S_RESP,
		S_LIST
	} state_t;

	// Control registers.
	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   hwm_q;
	logic [IW-1:0]   head_q;
	logic            out_valid_q;

	// Working registers.
	logic [bll_pkg::OP_W-1:0] op_q;
	logic [SW-1:0]            key_q;
	logic [bll_pkg::POS_W-1:0] pos_q;
	logic [IW-1:0]            fhead_q;
	logic [IW-1:0]            slot_q;
	logic [IW-1:0]            cur_q;
	logic [IW-1:0]            prev_q;
	logic [CW-1:0]            step_q;
	logic [CW-1:0]            target_q;
	logic [CW-1:0]            target_d;
	bll_pkg::status_t         status_q, status_d;
	logic                     status_set;

	// Output register payload.
	bll_pkg::status_t            out_status_q;
	logic [bll_pkg::ELEM_W-1:0]  out_elem_q;
	logic                        out_has_q;
	logic                        out_last_q;
	logic [bll_pkg::LEN_W-1:0]   out_len_q;

	// Memory ports.
	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	logic [SW-1:0]   val_rd;
	logic [IW-1:0]   link_rd;
	logic            vwe;
	logic            lwe;
	logic [IW-1:0]   lwaddr;
	logic [IW-1:0]   lwdata;

	// Sequencer strobes.
	logic            accept_in;
	logic            room;
	logic            is_full;
	logic            free_avail;
	logic            pos_ge;
	logic            push_like;
	logic            walk_done;
	logic            key_hit;
	logic            list_last;
	logic            take_hwm;
	logic            do_clear;
	logic            count_inc;
	logic            count_dec;
	logic            head_load;
	logic [IW-1:0]   head_d;
	logic            fhead_from_link;
	logic            fhead_from_cur;
	logic            slot_from_cur;
	logic            step_clr;
	logic            advance;
	logic            out_load;
	logic            out_has_d;
	logic            out_last_d;

	// Value and link stores.
	bll_node_ram #(
		.WIDTH (SW),
		.DEPTH (DEPTH)
	) u_value_ram (
		.clk   (clk),
		.we    (vwe),
		.waddr (slot_q),
		.wdata (key_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (val_rd)
	);

	bll_node_ram #(
		.WIDTH (IW),
		.DEPTH (DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (lwe),
		.waddr (lwaddr),
		.wdata (lwdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (link_rd)
	);

	// Handshake and shared compare flags.
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept_in     = s_axis_tvalid && s_axis_tready;
	assign room          = !out_valid_q || m_axis_tready;
	assign is_full       = (count_q == CW'(DEPTH));
	assign free_avail    = (count_q != hwm_q);
	assign pos_ge        = (CMPW'(pos_q) >= CMPW'(count_q));
	assign push_like     = (op_q == bll_pkg::OP_PUSH) || (count_q == '0);
	assign walk_done     = (step_q == target_q);
	assign key_hit       = (val_rd == key_q);
	assign list_last     = (step_q == count_q - CW'(1));

	// Walk target: tail for append, stored length for key search, else the position.
	always_comb begin
		case (op_q)
			bll_pkg::OP_APPEND:  target_d = count_q - CW'(1);
			bll_pkg::OP_DEL_KEY: target_d = count_q;
			default:             target_d = CW'(pos_q);
		endcase
	end

	// Sequencer next state, memory controls and update strobes.
	always_comb begin
		state_d         = state_q;
		rd_en           = 1'b0;
		rd_addr         = link_rd;
		vwe             = 1'b0;
		lwe             = 1'b0;
		lwaddr          = cur_q;
		lwdata          = link_rd;
		status_set      = 1'b0;
		status_d        = bll_pkg::STAT_OK;
		take_hwm        = 1'b0;
		do_clear        = 1'b0;
		count_inc       = 1'b0;
		count_dec       = 1'b0;
		head_load       = 1'b0;
		head_d          = link_rd;
		fhead_from_link = 1'b0;
		fhead_from_cur  = 1'b0;
		slot_from_cur   = 1'b0;
		step_clr        = 1'b0;
		advance         = 1'b0;
		out_load        = 1'b0;
		out_has_d       = 1'b0;
		out_last_d      = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept_in) begin
					rd_en    = 1'b1;
					rd_addr  = head_q;
					step_clr = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				status_set = 1'b1;
				state_d    = S_RESP;
				unique case (op_q) inside
					bll_pkg::OP_PUSH, bll_pkg::OP_APPEND, bll_pkg::OP_INSERT: begin
						if ((op_q == bll_pkg::OP_INSERT) && pos_ge) begin
							status_d = bll_pkg::STAT_NOT_FOUND;
						end else if (is_full) begin
							status_d = bll_pkg::STAT_FULL;
						end else if (free_avail) begin
							rd_en   = 1'b1;
							rd_addr = fhead_q;
							state_d = S_ALLOC;
						end else begin
							take_hwm = 1'b1;
							state_d  = push_like ? S_PUSH : S_WALK;
						end
					end
					bll_pkg::OP_DEL_KEY: begin
						state_d = S_WALK;
					end
					bll_pkg::OP_DEL_AT: begin
						if (pos_ge) begin
							status_d = bll_pkg::STAT_NOT_FOUND;
						end else begin
							state_d = S_WALK;
						end
					end
					bll_pkg::OP_CLEAR: begin
						do_clear = 1'b1;
					end
					bll_pkg::OP_LIST: begin
						if (count_q != '0) begin
							state_d = S_LIST;
						end
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_ALLOC: begin
				// Pop the free list and restart the walk at the head.
				fhead_from_link = 1'b1;
				slot_from_cur   = 1'b1;
				rd_en           = 1'b1;
				rd_addr         = head_q;
				step_clr        = 1'b1;
				state_d         = push_like ? S_PUSH : S_WALK;
			end
			S_PUSH: begin
				vwe       = 1'b1;
				lwe       = 1'b1;
				lwaddr    = slot_q;
				lwdata    = head_q;
				head_load = 1'b1;
				head_d    = slot_q;
				count_inc = 1'b1;
				state_d   = S_RESP;
			end
			S_WALK: begin
				unique case (op_q) inside
					bll_pkg::OP_APPEND, bll_pkg::OP_INSERT: begin
						if (walk_done) begin
							vwe     = 1'b1;
							lwe     = 1'b1;
							lwaddr  = slot_q;
							lwdata  = link_rd;
							state_d = S_INS_W2;
						end else begin
							rd_en   = 1'b1;
							advance = 1'b1;
						end
					end
					bll_pkg::OP_DEL_AT, bll_pkg::OP_DEL_KEY: begin
						if (walk_done && (op_q == bll_pkg::OP_DEL_KEY)) begin
							status_set = 1'b1;
							status_d   = bll_pkg::STAT_NOT_FOUND;
							state_d    = S_RESP;
						end else if (walk_done || key_hit && (op_q == bll_pkg::OP_DEL_KEY)) begin
							// Unlink the current node from its predecessor or the head.
							if (step_q == '0) begin
								head_load = 1'b1;
							end else begin
								lwe    = 1'b1;
								lwaddr = prev_q;
							end
							state_d = S_FREE;
						end else begin
							rd_en   = 1'b1;
							advance = 1'b1;
						end
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_INS_W2: begin
				lwe       = 1'b1;
				lwaddr    = cur_q;
				lwdata    = slot_q;
				count_inc = 1'b1;
				state_d   = S_RESP;
			end
			S_FREE: begin
				// Push the removed node onto the free list.
				lwe            = 1'b1;
				lwaddr         = cur_q;
				lwdata         = fhead_q;
				fhead_from_cur = 1'b1;
				count_dec      = 1'b1;
				state_d        = S_RESP;
			end
			S_RESP: begin
				if (room) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_LIST: begin
				if (room) begin
					out_load   = 1'b1;
					out_has_d  = 1'b1;
					out_last_d = list_last;
					rd_en      = 1'b1;
					advance    = 1'b1;
					if (list_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, list bookkeeping and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			hwm_q       <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_clear) begin
				count_q <= '0;
				hwm_q   <= '0;
				head_q  <= '0;
			end else begin
				if (count_inc) begin
					count_q <= count_q + CW'(1);
				end else if (count_dec) begin
					count_q <= count_q - CW'(1);
				end
				if (take_hwm) begin
					hwm_q <= hwm_q + CW'(1);
				end
				if (head_load) begin
					head_q <= head_d;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and output payload.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			op_q  <= s_axis_tdata[2:0];
			key_q <= SW'(s_axis_tdata[34:3]);
			pos_q <= s_axis_tdata[38:35];
		end
		if (rd_en) begin
			cur_q <= rd_addr;
		end
		if (step_clr) begin
			step_q <= '0;
		end else if (advance) begin
			step_q <= step_q + CW'(1);
			prev_q <= cur_q;
		end
		if (state_q == S_DISPATCH) begin
			target_q <= target_d;
		end
		if (take_hwm) begin
			slot_q <= IW'(hwm_q);
		end else if (slot_from_cur) begin
			slot_q <= cur_q;
		end
		if (fhead_from_link) begin
			fhead_q <= link_rd;
		end else if (fhead_from_cur) begin
			fhead_q <= cur_q;
		end
		if (status_set) begin
			status_q <= status_d;
		end
		if (out_load) begin
			out_status_q <= out_has_d ? bll_pkg::STAT_OK : status_q;
			out_elem_q   <= out_has_d ? bll_pkg::ELEM_W'(val_rd) : '0;
			out_has_q    <= out_has_d;
			out_last_q   <= out_last_d;
			out_len_q    <= bll_pkg::LEN_W'(count_q);
		end
	end

	// Output channel.
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_len_q, out_elem_q, out_status_q};
	assign m_axis_tuser  = out_has_q;
	assign m_axis_tlast  = out_last_q;

	// Assertions.
	`BLL_ASSERT(a_count_le_hwm, count_q <= hwm_q, "list length exceeds allocated slots")
	`BLL_ASSERT(a_hwm_le_depth, hwm_q <= CW'(DEPTH), "high-water mark beyond node store")
	`BLL_ASSERT(a_fresh_only_when_no_free, !take_hwm || (count_q == hwm_q), "fresh slot taken while free list holds nodes")
	`BLL_ASSERT_NEXT(a_busy_after_accept, accept_in, !s_axis_tready, "engine ready right after a transaction")

endmodule

FILE: verif/tb.sv
// Testbench for the bounded linked list engine: stream stimulus, list predictor and result checker.
`timescale 1ns / 100ps

module tb;

	localparam int LIST_DEPTH   = bll_pkg::DEPTH_DEF;
	localparam int RESET_CYCLES = 11;
	localparam int HOLD_CYCLES  = 120;
	localparam int QUIET_LIMIT  = 1000;
	localparam int CALM_ITEMS   = 25;
	localparam int PRINT_LIMIT  = 40;

	// Kinds of entries in the stimulus backlog.
	typedef enum logic [1:0] {
		STEP_ITEM,
		STEP_DRAIN,
		STEP_HOLD
	} step_kind_t;

	typedef struct packed {
		step_kind_t    kind;
		bll_pkg::op_t  op;
		logic [31:0]   value;
		logic [3:0]    position;
	} list_cmd_t;

	typedef struct packed {
		bll_pkg::status_t status;
		logic [31:0]      element;
		logic             has_element;
		logic             last;
		logic [4:0]       length;
	} list_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [bll_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [bll_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	bounded_linked_list_engine_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Predicted list contents, front first, and the results still owed by the engine.
	logic [31:0]  list_contents[$];
	list_result_t predicted_results[$];
	list_cmd_t    op_backlog[$];

	logic [31:0] key_pool[8];
	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	logic        in_fire = 1'b0;
	logic        hold_req = 1'b0;
	logic        hold_taken = 1'b0;
	int          rx_hold = 0;
	int          rx_gap = 0;
	int          tx_gap = 0;

	// Clock with a 4 ns period.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < PRINT_LIMIT) begin
			$display("%0t: %s: got %h, want %h", $time, what, got, want);
		end
		mismatch_count++;
	endtask

	task automatic owe_result(input bll_pkg::status_t status, input logic [31:0] element,
			input logic has_element, input logic last);
		list_result_t res;
		res.status      = status;
		res.element     = element;
		res.has_element = has_element;
		res.last        = last;
		res.length      = 5'(list_contents.size());
		predicted_results.push_back(res);
	endtask

	// Applies one accepted operation to the predicted list and records its results.
	task automatic apply_list_op(input logic [2:0] op_bits, input logic [31:0] value,
			input logic [3:0] position);
		int hit;
		bll_pkg::status_t status;
		hit    = -1;
		status = bll_pkg::STAT_OK;
		case (op_bits)
			bll_pkg::OP_PUSH: begin
				if (list_contents.size() == LIST_DEPTH) status = bll_pkg::STAT_FULL;
				else list_contents.push_front(value);
			end
			bll_pkg::OP_APPEND: begin
				if (list_contents.size() == LIST_DEPTH) status = bll_pkg::STAT_FULL;
				else list_contents.push_back(value);
			end
			bll_pkg::OP_INSERT: begin
				// A bad position wins over a full store.
				if (position >= list_contents.size()) status = bll_pkg::STAT_NOT_FOUND;
				else if (list_contents.size() == LIST_DEPTH) status = bll_pkg::STAT_FULL;
				else list_contents.insert(position + 1, value);
			end
			bll_pkg::OP_DEL_KEY: begin
				for (int i = 0; i < list_contents.size(); i++) begin
					if (hit < 0 && list_contents[i] == value) hit = i;
				end
				if (hit < 0) status = bll_pkg::STAT_NOT_FOUND;
				else list_contents.delete(hit);
			end
			bll_pkg::OP_DEL_AT: begin
				if (position >= list_contents.size()) status = bll_pkg::STAT_NOT_FOUND;
				else list_contents.delete(position);
			end
			bll_pkg::OP_CLEAR: begin
				list_contents.delete();
			end
			bll_pkg::OP_LIST: begin
				// An empty list still answers with one plain result.
				if (list_contents.size() == 0) begin
					owe_result(bll_pkg::STAT_OK, '0, 1'b0, 1'b1);
				end else begin
					for (int i = 0; i < list_contents.size(); i++) begin
						owe_result(bll_pkg::STAT_OK, list_contents[i], 1'b1,
							i == list_contents.size() - 1);
					end
				end
				return;
			end
			default: begin
			end
		endcase
		owe_result(status, '0, 1'b0, 1'b1);
	endtask

	// Compares one accepted result with the oldest prediction, field by field.
	task automatic check_list_result(input logic [bll_pkg::OUT_TDATA_W-1:0] word,
			input logic has_element, input logic last);
		list_result_t want;
		if (predicted_results.size() == 0) begin
			report_mismatch("result with no prediction", word[33:2], '0);
			return;
		end
		want = predicted_results.pop_front();
		if (word[1:0] !== want.status) report_mismatch("status", word[1:0], want.status);
		if (word[33:2] !== want.element) report_mismatch("element", word[33:2], want.element);
		if (has_element !== want.has_element) begin
			report_mismatch("has_element", has_element, want.has_element);
		end
		if (last !== want.last) report_mismatch("last", last, want.last);
		if (word[38:34] !== want.length) report_mismatch("length", word[38:34], want.length);
	endtask

	// Sample both sides at the rising edge and feed the predictor and checker.
	always @(posedge clk) begin
		if (arst_n) begin
			in_fire <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				apply_list_op(s_axis_tdata[2:0], s_axis_tdata[34:3], s_axis_tdata[38:35]);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				check_list_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Input driver: offers backlog items at the falling edge, with random idle bursts.
	always @(negedge clk) begin
		list_cmd_t nxt;
		logic give;
		give = 1'b0;
		if (arst_n && !(s_axis_tvalid && !in_fire)) begin
			if (op_backlog.size() > 0 && op_backlog[0].kind == STEP_HOLD) begin
				hold_req <= 1'b1;
				void'(op_backlog.pop_front());
			end
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (op_backlog.size() > CALM_ITEMS && $urandom_range(0, 11) == 0) begin
				tx_gap = $urandom_range(1, 15) - 1;
			end else if (op_backlog.size() > 0) begin
				if (op_backlog[0].kind == STEP_DRAIN) begin
					// Wait for every owed result before going on.
					if (predicted_results.size() == 0) void'(op_backlog.pop_front());
				end else begin
					nxt  = op_backlog.pop_front();
					give = 1'b1;
					s_axis_tdata <= {1'b0, nxt.position, nxt.value, nxt.op};
				end
			end
			s_axis_tvalid <= give;
		end
	end

	// Output receiver: ready with random stalls and one long hold-off.
	always @(negedge clk) begin
		logic rdy;
		rdy = 1'b1;
		if (arst_n) begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				rx_hold    = HOLD_CYCLES;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				rdy = 1'b0;
			end else if (op_backlog.size() <= CALM_ITEMS) begin
				rdy = 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				rdy = 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				rx_gap = $urandom_range(1, 15) - 1;
				rdy    = 1'b0;
			end
			m_axis_tready <= rdy;
		end
	end

	task automatic queue_op(input bll_pkg::op_t op, input logic [31:0] value,
			input logic [3:0] position);
		list_cmd_t cmd;
		cmd.kind     = STEP_ITEM;
		cmd.op       = op;
		cmd.value    = value;
		cmd.position = position;
		op_backlog.push_back(cmd);
	endtask

	task automatic queue_marker(input step_kind_t kind);
		list_cmd_t cmd;
		cmd          = '0;
		cmd.kind     = kind;
		cmd.op       = bll_pkg::OP_LIST;
		op_backlog.push_back(cmd);
	endtask

	function automatic logic [31:0] pick_value();
		// Mostly values from a small pool, so that key deletes often hit.
		if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic logic [3:0] pick_position();
		if ($urandom_range(0, 9) < 7) return 4'($urandom_range(0, 4));
		return 4'($urandom_range(0, 15));
	endfunction

	// Random operations; grow_pct sets the share of operations that add elements.
	task automatic queue_random_ops(input int count, input int grow_pct);
		int r;
		bll_pkg::op_t op;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < grow_pct) begin
				case (r % 3)
					0: op = bll_pkg::OP_PUSH;
					1: op = bll_pkg::OP_APPEND;
					default: op = bll_pkg::OP_INSERT;
				endcase
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: op = bll_pkg::OP_DEL_KEY;
					4, 5, 6: op = bll_pkg::OP_DEL_AT;
					7, 8: op = bll_pkg::OP_LIST;
					default: op = bll_pkg::OP_CLEAR;
				endcase
			end
			queue_op(op, pick_value(), pick_position());
		end
	endtask

	initial begin
		logic [31:0] saved_key;
		logic [31:0] v;

		key_pool = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h1,
			32'h55555555, $urandom, $urandom};

		// Directed: empty list cases, value extremes, positions at both ends.
		queue_op(bll_pkg::OP_LIST, 32'h0, 4'd0);
		queue_op(bll_pkg::OP_DEL_AT, 32'h0, 4'd0);
		queue_op(bll_pkg::OP_DEL_KEY, 32'h0, 4'd0);
		queue_op(bll_pkg::OP_INSERT, 32'h1, 4'd0);
		queue_op(bll_pkg::OP_PUSH, 32'h7fffffff, 4'd0);
		queue_op(bll_pkg::OP_APPEND, 32'h80000000, 4'd0);
		queue_op(bll_pkg::OP_INSERT, 32'h0, 4'd0);
		queue_op(bll_pkg::OP_INSERT, 32'hffffffff, 4'd2);
		queue_op(bll_pkg::OP_INSERT, 32'h2, 4'd15);
		queue_op(bll_pkg::OP_DEL_AT, 32'h0, 4'd15);
		queue_op(bll_pkg::OP_DEL_KEY, 32'h12345678, 4'd0);
		queue_op(bll_pkg::OP_LIST, 32'h0, 4'd0);
		queue_op(bll_pkg::OP_DEL_KEY, 32'h0, 4'd0);
		queue_op(bll_pkg::OP_DEL_AT, 32'h0, 4'd0);
		queue_op(bll_pkg::OP_DEL_AT, 32'h0, 4'd1);
		queue_op(bll_pkg::OP_DEL_KEY, 32'h80000000, 4'd0);
		queue_op(bll_pkg::OP_LIST, 32'h0, 4'd0);
		queue_op(bll_pkg::OP_CLEAR, 32'h0, 4'd0);
		queue_op(bll_pkg::OP_PUSH, 32'h55555555, 4'd0);
		queue_op(bll_pkg::OP_APPEND, 32'haaaaaaaa, 4'd0);

		// Fill the store, then hit it while full; the long hold-off lands on a full list.
		queue_op(bll_pkg::OP_CLEAR, 32'h0, 4'd0);
		saved_key = '0;
		for (int n = 0; n < LIST_DEPTH; n++) begin
			v = $urandom;
			if (n == 7) saved_key = v;
			queue_op($urandom_range(0, 1) ? bll_pkg::OP_PUSH : bll_pkg::OP_APPEND, v, 4'd0);
		end
		queue_op(bll_pkg::OP_PUSH, 32'h1, 4'd0);
		queue_op(bll_pkg::OP_APPEND, 32'h2, 4'd0);
		queue_op(bll_pkg::OP_INSERT, 32'h3, 4'd15);
		queue_marker(STEP_HOLD);
		queue_op(bll_pkg::OP_LIST, 32'h0, 4'd0);
		queue_op(bll_pkg::OP_DEL_AT, 32'h0, 4'd15);
		queue_op(bll_pkg::OP_DEL_KEY, saved_key, 4'd0);
		queue_op(bll_pkg::OP_LIST, 32'h0, 4'd0);
		queue_marker(STEP_DRAIN);

		// Random phases: growing, shrinking, then mixed.
		queue_random_ops(20, 75);
		queue_marker(STEP_DRAIN);
		queue_random_ops(15, 25);
		queue_random_ops(20, 50);
		queue_op(bll_pkg::OP_LIST, 32'h0, 4'd0);

		// Single reset at the start of the run.
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do begin
			@(posedge clk);
		end while (op_backlog.size() != 0 || s_axis_tvalid || predicted_results.size() != 0);
		repeat (2 * LIST_DEPTH) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog: ends the run when no transaction moves for too long.
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Mismatches found");
		$finish;
	end

endmodule
